// File: design/lrc_pkg.sv
package lrc_pkg;

    localparam int KEY_W        = 32;
    localparam int CNT_W        = 32;
    localparam int CAP_W        = 5;
    localparam int WAYS_DEFAULT = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // what one access does to the tag store
    typedef struct packed {
        logic hit;
        logic fill;
        logic evict;
    } t_action;

    // running totals, saturating
    typedef struct packed {
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] eviction_total;
    } t_totals;

endpackage

// File: design/lrc_lookup.sv
module lrc_lookup #(
    parameter int WAYS = lrc_pkg::WAYS_DEFAULT,
    parameter int RW   = (WAYS > 1) ? $clog2(WAYS) : 1,
    parameter int OW   = $clog2(WAYS + 1)
) (
    input  logic [lrc_pkg::KEY_W-1:0] i_key,
    input  logic [lrc_pkg::KEY_W-1:0] i_tags [WAYS],
    input  logic [WAYS-1:0]           i_valid,
    input  logic [RW-1:0]             i_ranks [WAYS],
    input  logic [OW-1:0]             i_occ,
    input  logic [lrc_pkg::CAP_W-1:0] i_capacity,
    output lrc_pkg::t_action          o_action,
    output logic [WAYS-1:0]           o_sel_oh,
    output logic [RW-1:0]             o_sel_rank,
    output logic [lrc_pkg::KEY_W-1:0] o_ev_key
);
    import lrc_pkg::*;

    localparam int CW = (OW > CAP_W) ? OW : CAP_W;

    logic [WAYS-1:0] match;
    logic [WAYS-1:0] hit_oh;
    logic [WAYS-1:0] free;
    logic [WAYS-1:0] free_oh;
    logic [WAYS-1:0] vic;
    logic [WAYS-1:0] vic_oh;
    logic [RW-1:0]   vic_rank;
    logic [CW-1:0]   cap_ext;
    logic [CW-1:0]   eff_cap;
    logic            fill_ok;
    logic            hit;
    logic            fill;

    // LRU way holds the highest rank, which is occupancy - 1
    assign vic_rank = RW'(i_occ - OW'(1));

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            match[i] = i_valid[i] && (i_tags[i] == i_key);
            vic[i]   = i_valid[i] && (i_ranks[i] == vic_rank);
        end
    end

    // isolate lowest set bit
    assign hit_oh  = match & (~match + WAYS'(1));
    assign free    = ~i_valid;
    assign free_oh = free & (~free + WAYS'(1));
    assign vic_oh  = vic & (~vic + WAYS'(1));

    // capacity clamped to 1..WAYS
    assign cap_ext = CW'(i_capacity);
    always_comb begin
        if (cap_ext == '0) begin
            eff_cap = CW'(1);
        end else if (cap_ext > CW'(WAYS)) begin
            eff_cap = CW'(WAYS);
        end else begin
            eff_cap = cap_ext;
        end
    end
    assign fill_ok = CW'(i_occ) < eff_cap;

    assign hit  = |match;
    assign fill = !hit && fill_ok && (|free);

    assign o_action.hit   = hit;
    assign o_action.fill  = fill;
    assign o_action.evict = !hit && !fill;

    assign o_sel_oh = hit ? hit_oh : (fill ? free_oh : vic_oh);

    always_comb begin
        o_sel_rank = '0;
        o_ev_key   = '0;
        for (int i = 0; i < WAYS; i++) begin
            if (o_sel_oh[i]) begin
                o_sel_rank = o_sel_rank | i_ranks[i];
            end
            if (vic_oh[i] && !hit && !fill) begin
                o_ev_key = o_ev_key | i_tags[i];
            end
        end
    end

endmodule

// File: design/lrc_stats.sv
module lrc_stats (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_strobe,
    input  lrc_pkg::t_action i_action,
    output lrc_pkg::t_totals o_totals
);
    import lrc_pkg::*;

    t_totals r_tot;
    t_totals n_tot;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + CNT_W'(1);
    endfunction

    always_comb begin
        n_tot = r_tot;
        if (i_strobe) begin
            if (i_action.hit) begin
                n_tot.hit_total = sat_inc(r_tot.hit_total);
            end else begin
                n_tot.miss_total = sat_inc(r_tot.miss_total);
            end
            if (i_action.evict) begin
                n_tot.eviction_total = sat_inc(r_tot.eviction_total);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot <= '0;
        end else begin
            r_tot <= n_tot;
        end
    end

    assign o_totals = r_tot;

endmodule

// File: design/lru_cache_replacement_top.sv
// Fully associative LRU tag store. One access key is taken per clock (start while busy is
// low; busy never rises) and its result appears on the o_ ports through the key and result
// registers, marked by o_result_valid for exactly one cycle. The receiver cannot stall: each
// result transaction must be captured in the cycle it is strobed, and a steady stream of one
// key per cycle gives one result per cycle. The rate is set by the single parallel compare of
// all ways and the rank update after it, both between the key and state/result registers. The
// user must write capacity through the config channel (always ready) only while idle; the
// block does not check it. Zero acts as one, above WAYS as WAYS. Totals saturate at all ones.
module lru_cache_replacement_top #(
    parameter int WAYS = lrc_pkg::WAYS_DEFAULT,
    parameter int RW   = (WAYS > 1) ? $clog2(WAYS) : 1,
    parameter int OW   = $clog2(WAYS + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // access channel
    input  logic                      start,
    output logic                      busy,
    input  logic [lrc_pkg::KEY_W-1:0] i_access_key,
    // capacity write channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [lrc_pkg::CAP_W-1:0] i_cfg_data,
    // result channel
    output logic                      o_result_valid,
    output logic                      o_hit,
    output logic                      o_evicted,
    output logic [lrc_pkg::KEY_W-1:0] o_evicted_key,
    output logic [lrc_pkg::CNT_W-1:0] o_hit_total,
    output logic [lrc_pkg::CNT_W-1:0] o_miss_total,
    output logic [lrc_pkg::CNT_W-1:0] o_eviction_total
);
    import lrc_pkg::*;

    // input register
    logic             r_in_vld;
    logic [KEY_W-1:0] r_key;

    // tag store state
    logic [KEY_W-1:0] r_tags  [WAYS];
    logic [WAYS-1:0]  r_valid;
    logic [RW-1:0]    r_ranks [WAYS];
    logic [OW-1:0]    r_occ;
    logic [CAP_W-1:0] r_capacity;

    // result register (totals live in lrc_stats)
    logic             r_res_vld;
    logic             r_hit;
    logic             r_evicted;
    logic [KEY_W-1:0] r_ev_key;

    // lookup outputs
    t_action          action;
    logic [WAYS-1:0]  sel_oh;
    logic [RW-1:0]    sel_rank;
    logic [KEY_W-1:0] ev_key;
    t_totals          totals;

    // one access per cycle; config is always taken
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_capacity <= i_cfg_data;
        end
    end

    // stage 1: capture the key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_key <= i_access_key;
        end
    end

    // compare against every way, pick hit, free or LRU way
    lrc_lookup #(
        .WAYS (WAYS),
        .RW   (RW),
        .OW   (OW)
    ) u_lookup (
        .i_key      (r_key),
        .i_tags     (r_tags),
        .i_valid    (r_valid),
        .i_ranks    (r_ranks),
        .i_occ      (r_occ),
        .i_capacity (r_capacity),
        .o_action   (action),
        .o_sel_oh   (sel_oh),
        .o_sel_rank (sel_rank),
        .o_ev_key   (ev_key)
    );

    // stage 2: tag write into the selected way (a hit rewrites the same key)
    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            for (int i = 0; i < WAYS; i++) begin
                if (sel_oh[i]) begin
                    r_tags[i] <= r_key;
                end
            end
        end
    end

    // selected way becomes MRU; ways more recent than it age by one.
    // On a fill every other valid way ages; on an eviction the victim is the
    // oldest so again every other valid way ages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            for (int i = 0; i < WAYS; i++) begin
                r_ranks[i] <= '0;
            end
        end else if (r_in_vld) begin
            for (int i = 0; i < WAYS; i++) begin
                if (sel_oh[i]) begin
                    r_valid[i] <= 1'b1;
                    r_ranks[i] <= '0;
                end else if (r_valid[i] && (action.fill || r_ranks[i] < sel_rank)) begin
                    r_ranks[i] <= r_ranks[i] + RW'(1);
                end
            end
            if (action.fill) begin
                r_occ <= r_occ + OW'(1);
            end
        end
    end

    lrc_stats u_stats (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_strobe (r_in_vld),
        .i_action (action),
        .o_totals (totals)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_hit     <= action.hit;
            r_evicted <= action.evict;
            r_ev_key  <= ev_key;
        end
    end

    assign o_result_valid   = r_res_vld;
    assign o_hit            = r_hit;
    assign o_evicted        = r_evicted;
    assign o_evicted_key    = r_ev_key;
    assign o_hit_total      = totals.hit_total;
    assign o_miss_total     = totals.miss_total;
    assign o_eviction_total = totals.eviction_total;

    // every accepted key yields a strobed result through the key and result registers
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_result_valid)
        else $error("result strobe missing after accepted access");

    // occupancy tracks the valid bits
    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_occ))
        else $error("occupancy count out of step with valid bits");

    // a hit never evicts, and a result without an eviction reports a zero key
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !(o_hit && o_evicted))
        else $error("hit and eviction reported together");

    a_ev_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_evicted) |-> (o_evicted_key == '0))
        else $error("evicted key nonzero without eviction");

endmodule

// File: dv/lru_cache_replacement_top_tb.sv
`timescale 1ns / 1ps

// Testbench for the fully associative LRU tag store.
// A behavioral tag store (tags, valid bits, recency ranks, occupancy and
// saturating totals) runs beside the DUT. Each access transaction accepted
// at the DUT produces one predicted outcome, queued in order. Every strobed
// result is compared against the oldest queued outcome.
// A short directed sequence covers the key extremes, hits, fills, evictions,
// capacity of zero, capacity above the way count, and capacity dropped below
// the current occupancy. Randomized phases follow, each at its own capacity,
// drawing keys mostly from a small per-phase pool so that hits, LRU reordering
// and evictions all occur often, with a share of fresh random keys as noise.
module lru_cache_replacement_top_tb;

    import lrc_pkg::*;

    localparam int NUM_WAYS    = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    // one result transaction as seen on the result ports
    typedef struct packed {
        logic             hit;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] eviction_total;
    } t_outcome;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [KEY_W-1:0] i_access_key;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CAP_W-1:0] i_cfg_data;
    logic             o_result_valid;
    logic             o_hit;
    logic             o_evicted;
    logic [KEY_W-1:0] o_evicted_key;
    logic [CNT_W-1:0] o_hit_total;
    logic [CNT_W-1:0] o_miss_total;
    logic [CNT_W-1:0] o_eviction_total;

    lru_cache_replacement_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_access_key     (i_access_key),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_result_valid   (o_result_valid),
        .o_hit            (o_hit),
        .o_evicted        (o_evicted),
        .o_evicted_key    (o_evicted_key),
        .o_hit_total      (o_hit_total),
        .o_miss_total     (o_miss_total),
        .o_eviction_total (o_eviction_total)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Shadow tag store
    // ------------------------------------------------------------------
    logic [KEY_W-1:0] shadow_tag   [NUM_WAYS];
    logic             shadow_valid [NUM_WAYS];
    logic [3:0]       shadow_rank  [NUM_WAYS];
    logic [4:0]       shadow_occupied;
    logic [CNT_W-1:0] shadow_hits;
    logic [CNT_W-1:0] shadow_misses;
    logic [CNT_W-1:0] shadow_evictions;
    logic [CAP_W-1:0] shadow_capacity;

    t_outcome outcome_q [$];

    int cycle_count;
    int mismatches;
    int accesses_sent;
    int hits_seen;
    int evictions_seen;
    int cap_writes;

    function automatic logic [CNT_W-1:0] sat_incr(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // capacity of zero acts as one, anything past the way count acts as the way count
    function automatic int effective_ways(input logic [CAP_W-1:0] c);
        int n;
        n = int'(c);
        if (n < 1) n = 1;
        if (n > NUM_WAYS) n = NUM_WAYS;
        return n;
    endfunction

    // age every valid way ranked below the limit, then make way w the most recent
    function automatic void make_mru(input int w, input int limit);
        for (int i = 0; i < NUM_WAYS; i++) begin
            if (shadow_valid[i] && i != w && int'(shadow_rank[i]) < limit)
                shadow_rank[i] = shadow_rank[i] + 1'b1;
        end
        shadow_rank[w] = '0;
    endfunction

    function automatic t_outcome predict_access(input logic [KEY_W-1:0] key);
        t_outcome res;
        int       way;
        int       victim;
        way    = -1;
        victim = -1;
        res    = '0;
        for (int i = 0; i < NUM_WAYS; i++) begin
            if (way < 0 && shadow_valid[i] && shadow_tag[i] == key)
                way = i;
        end
        if (way >= 0) begin
            res.hit     = 1'b1;
            shadow_hits = sat_incr(shadow_hits);
            make_mru(way, int'(shadow_rank[way]));
        end else begin
            shadow_misses = sat_incr(shadow_misses);
            if (int'(shadow_occupied) < effective_ways(shadow_capacity)) begin
                for (int i = 0; i < NUM_WAYS; i++) begin
                    if (way < 0 && !shadow_valid[i])
                        way = i;
                end
            end
            if (way >= 0) begin
                // free way available: fill it
                shadow_valid[way] = 1'b1;
                shadow_tag[way]   = key;
                shadow_occupied   = shadow_occupied + 1'b1;
                make_mru(way, 255);
            end else begin
                // evict the valid way with the oldest rank
                for (int i = 0; i < NUM_WAYS; i++) begin
                    if (shadow_valid[i] &&
                        (victim < 0 || shadow_rank[i] > shadow_rank[victim]))
                        victim = i;
                end
                if (victim < 0) victim = 0;
                res.evicted          = 1'b1;
                res.evicted_key      = shadow_tag[victim];
                shadow_evictions     = sat_incr(shadow_evictions);
                shadow_tag[victim]   = key;
                shadow_valid[victim] = 1'b1;
                make_mru(victim, int'(shadow_rank[victim]));
            end
        end
        res.hit_total      = shadow_hits;
        res.miss_total     = shadow_misses;
        res.eviction_total = shadow_evictions;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: checks strobed results, then predicts any accepted access.
    // Both happen in one process so their order at an edge is fixed.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_outcome got;
        t_outcome want;
        if (i_rst_n) begin
            if (o_result_valid) begin
                got = '{o_hit, o_evicted, o_evicted_key,
                        o_hit_total, o_miss_total, o_eviction_total};
                hits_seen      += int'(o_hit);
                evictions_seen += int'(o_evicted);
                if (outcome_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("[%0t] unexpected result transaction: %p", $realtime, got);
                end else begin
                    want = outcome_q[0];
                    outcome_q.delete(0);
                    if (got.hit !== want.hit || got.evicted !== want.evicted ||
                        got.evicted_key !== want.evicted_key ||
                        got.hit_total !== want.hit_total ||
                        got.miss_total !== want.miss_total ||
                        got.eviction_total !== want.eviction_total) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("[%0t] result mismatch", $realtime);
                            $display("    expected hit=%0b evict=%0b key=%h tot h/m/e=%0d/%0d/%0d",
                                     want.hit, want.evicted, want.evicted_key,
                                     want.hit_total, want.miss_total, want.eviction_total);
                            $display("    actual   hit=%0b evict=%0b key=%h tot h/m/e=%0d/%0d/%0d",
                                     got.hit, got.evicted, got.evicted_key,
                                     got.hit_total, got.miss_total, got.eviction_total);
                        end
                    end
                end
            end
            if (start && !busy) begin
                outcome_q.insert(outcome_q.size(), predict_access(i_access_key));
                accesses_sent++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d outcomes pending",
                     cycle_count, outcome_q.size());
            $display("FAIL lru_cache_replacement_top");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks (drive on falling edge, sample on rising edge)
    // ------------------------------------------------------------------

    // present one key and hold it until the access transaction is taken
    task automatic send_access(input logic [KEY_W-1:0] key);
        @(negedge i_clk);
        start        <= 1'b1;
        i_access_key <= key;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            start        <= 1'b0;
            i_access_key <= $urandom;   // junk on the key bus while idle
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // stop sending and wait for every outstanding result, plus pipeline slack
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow_capacity = value;
        cap_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset capacity: key extremes, fills and hits
    task automatic test_fill_and_hit();
        send_access(32'h0000_0000);
        send_access(32'hFFFF_FFFF);
        send_access(32'h0000_0000);     // hit, promotes way 0
        send_access(32'h1234_5678);
        send_access(32'hFFFF_FFFF);     // hit on the oldest rank
    endtask

    // capacity zero behaves as one; occupancy already above it
    task automatic test_capacity_zero();
        write_capacity(5'd0);
        send_access(32'h0000_0000);     // hit, no flush
        send_access(32'hDEAD_BEEF);     // miss evicts the oldest entry
        send_access(32'hCAFE_F00D);     // miss evicts again
        send_access(32'hCAFE_F00D);     // hit
    endtask

    // capacity past the way count saturates; free ways fill again
    task automatic test_capacity_above_ways();
        write_capacity(5'd31);
        send_access(32'h8000_0001);
        send_access(32'h7FFF_FFFE);
    endtask

    // capacity dropped below occupancy: each miss evicts, no growth
    task automatic test_shrink_below_occupancy();
        write_capacity(5'd2);
        send_access(32'h0F0F_0F0F);
        send_access(32'hF0F0_F0F0);
        send_access(32'h8000_0001);     // hit on a surviving entry
        send_access(32'h3C3C_3C3C);
    endtask

    // randomized traffic at one capacity, keys mostly from a small pool
    task automatic run_traffic_phase(input logic [CAP_W-1:0] cap_value, input int n_items,
                                     input bit pause_midway);
        logic [KEY_W-1:0] key_pool [$];
        logic [KEY_W-1:0] key;
        int               pool_size;
        int               burst_left;
        write_capacity(cap_value);
        pool_size = effective_ways(cap_value) + $urandom_range(0, 6);
        for (int i = 0; i < pool_size; i++) key_pool.insert(key_pool.size(), $urandom);
        burst_left = $urandom_range(1, 12);
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(0, 7) == 0)
                key = $urandom;         // fresh key, nearly always a miss
            else
                key = key_pool[$urandom_range(0, pool_size - 1)];
            send_access(key);
            if (pause_midway && n == n_items / 2)
                drain_results();
            burst_left--;
            if (burst_left == 0) begin
                idle_cycles($urandom_range(0, 6));
                // now and then a long back-to-back stretch
                burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
            end
        end
    endtask

    task automatic test_random_traffic();
        logic [CAP_W-1:0] caps [9];
        caps = '{5'd31, 5'd1, 5'd8, 5'd0, 5'd16, 5'd3, 5'd24, 5'd12, 5'd2};
        foreach (caps[p])
            run_traffic_phase(caps[p], 50, p == 4);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_access_key = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        foreach (shadow_tag[i]) begin
            shadow_tag[i]   = '0;
            shadow_valid[i] = 1'b0;
            shadow_rank[i]  = '0;
        end
        shadow_occupied  = '0;
        shadow_hits      = '0;
        shadow_misses    = '0;
        shadow_evictions = '0;
        shadow_capacity  = CAP_RESET;
        cycle_count      = 0;
        mismatches       = 0;
        accesses_sent    = 0;
        hits_seen        = 0;
        evictions_seen   = 0;
        cap_writes       = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_fill_and_hit();
        test_capacity_zero();
        test_capacity_above_ways();
        test_shrink_below_occupancy();
        test_random_traffic();

        drain_results();
        repeat (8) @(posedge i_clk);
        if (outcome_q.size() != 0) mismatches++;

        $display("covered %0d access transactions over %0d capacity writes (0..31)",
                 accesses_sent, cap_writes);
        $display("results showed %0d hits and %0d evictions; %0d mismatches",
                 hits_seen, evictions_seen, mismatches);
        if (mismatches == 0) begin
            $display("PASS lru_cache_replacement_top");
        end else begin
            $display("FAIL lru_cache_replacement_top");
        end
        $finish;
    end

endmodule
